// ===== design/two_level_thread_scheduler_defines.svh =====
// Assertion macros for the scheduler checker.
`ifndef TWO_LEVEL_THREAD_SCHEDULER_DEFINES_SVH
`define TWO_LEVEL_THREAD_SCHEDULER_DEFINES_SVH
`define TLTS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("label failed");
`define TLTS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("label failed");
`endif

// ===== design/tlts_pkg.sv =====
`default_nettype none
package tlts_pkg;
  localparam int MAX_THREADS = 64;
  localparam int NUM_CPUS    = 16;

  localparam logic [2:0] OP_SCHED  = 3'd0;
  localparam logic [2:0] OP_WAKE   = 3'd1;
  localparam logic [2:0] OP_BLOCK  = 3'd2;
  localparam logic [2:0] OP_CREATE = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [1:0] ST_NEW   = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;
  localparam logic [1:0] KIND_USER   = 2'd0;
  localparam logic [1:0] KIND_DRIVER = 2'd1;
  localparam logic [1:0] RS_OK   = 2'd0;
  localparam logic [1:0] RS_FULL = 2'd1;
  localparam logic [1:0] RS_NP   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_EXEC, S_POPRD, S_POPCHK, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic lookup;
    logic exec;
    logic pop_issue;
    logic pop_check;
    logic finish;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic is_sched;
    logic sched_done;
    logic pop_found;
    logic q_empty;
  } sts_t;
endpackage
`default_nettype wire

// ===== design/tlts_if.sv =====
`default_nettype none
interface tlts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [3:0] cpu_id;
  logic [5:0] thread_id;
  logic [1:0] thread_kind;
  modport source(output valid, opcode, cpu_id, thread_id, thread_kind, input ready);
  modport sink(input valid, opcode, cpu_id, thread_id, thread_kind, output ready);
endinterface

interface tlts_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] result_thread;
  logic [1:0] status;
  logic       needs_start;
  logic       switched;
  modport source(output valid, result_thread, status, needs_start, switched, input ready);
  modport sink(input valid, result_thread, status, needs_start, switched, output ready);
endinterface
`default_nettype wire

// ===== design/tlts_ram.sv =====
`default_nettype none
module tlts_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/tlts_ctrl.sv =====
`default_nettype none
module tlts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_fire,
  input  wire tlts_pkg::sts_t sts,
  output tlts_pkg::cmd_t     cmd,
  output logic               in_ready
);
  import tlts_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_EXEC;
      S_EXEC:   state_nxt = (sts.is_sched && !sts.sched_done) ? S_POPRD : S_OUT;
      S_POPRD:  state_nxt = sts.q_empty ? S_FIN : S_POPCHK;
      S_POPCHK: state_nxt = sts.pop_found ? S_FIN : S_POPRD;
      S_FIN:    state_nxt = S_OUT;
      S_OUT:    if (out_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_LOOK:   cmd.lookup = 1'b1;
      S_EXEC:   cmd.exec = 1'b1;
      S_POPRD:  cmd.pop_issue = 1'b1;
      S_POPCHK: cmd.pop_check = 1'b1;
      S_FIN:    cmd.finish = 1'b1;
      S_OUT:    cmd.out_valid = 1'b1;
      default:  cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/tlts_dp.sv =====
`default_nettype none
module tlts_dp #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlts_pkg::cmd_t cmd,
  output tlts_pkg::sts_t      sts,
  input  wire logic           in_fire,
  input  wire logic [2:0]     in_opcode,
  input  wire logic [3:0]     in_cpu_id,
  input  wire logic [5:0]     in_thread_id,
  input  wire logic [1:0]     in_thread_kind,
  input  wire logic           cfg_we,
  input  wire logic [5:0]     cfg_wdata,
  output logic      [5:0]     res_thread,
  output logic      [1:0]     res_status,
  output logic              res_ns,
  output logic              res_sw
);
  import tlts_pkg::*;
  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] QFULL = NW'(QUEUE_DEPTH);

  logic [5:0] idle_r;
  logic [MAX_THREADS-1:0] valid_r;
  logic [5:0] run_r [NUM_CPUS];
  logic [QW-1:0] dh_r, dt_r, uh_r, ut_r;
  logic [NW-1:0] dc_r, uc_r;
  logic [2:0] op_r;
  logic [3:0] cpu_r;
  logic [5:0] tid_r;
  logic [1:0] knd_r;
  logic [5:0] next_r;
  logic       src_drv_r;
  logic [5:0] res_thread_r, res_thread_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic       res_ns_r, res_ns_nxt;
  logic       res_sw_r, res_sw_nxt;

  logic       dwe, uwe;
  logic [5:0] pdata;
  logic [5:0] drd, urd;
  // thread table entry: {kind, status}; only read for threads whose valid bit is set
  logic          twe;
  logic [TW-1:0] twa, tra;
  logic [3:0]    twd, trd;

  tlts_ram #(.WIDTH(6), .DEPTH(QUEUE_DEPTH)) u_dq (
    .clk(clk), .we(dwe), .waddr(dt_r), .wdata(pdata), .raddr(dh_r), .rdata(drd));
  tlts_ram #(.WIDTH(6), .DEPTH(QUEUE_DEPTH)) u_uq (
    .clk(clk), .we(uwe), .waddr(ut_r), .wdata(pdata), .raddr(uh_r), .rdata(urd));
  tlts_ram #(.WIDTH(4), .DEPTH(MAX_THREADS)) u_tbl (
    .clk(clk), .we(twe), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd));

  function automatic logic pres(input logic [5:0] id, input logic [MAX_THREADS-1:0] v);
    logic r;
    r = 1'b0;
    if (32'(id) < MAX_THREADS) r = v[id[TW-1:0]];
    return r;
  endfunction

  logic cpu_ok, tid_ok;
  logic [5:0] cur;
  logic [TW-1:0] ci, ti, ni, look_a;
  logic d_full, u_full;
  logic cur_rdy;
  logic [5:0] popv;
  logic [TW-1:0] pi;
  logic [1:0] rk, rs;
  logic create_ok;

  assign cpu_ok = 32'(cpu_r) < NUM_CPUS;
  assign tid_ok = 32'(tid_r) < MAX_THREADS;
  assign cur    = run_r[cpu_r[CW-1:0]];
  assign ci     = cur[TW-1:0];
  assign ti     = tid_r[TW-1:0];
  assign ni     = next_r[TW-1:0];
  assign d_full = dc_r >= QFULL;
  assign u_full = uc_r >= QFULL;
  assign rk     = trd[3:2];
  assign rs     = trd[1:0];
  assign cur_rdy = pres(cur, valid_r) && rs == ST_READY;
  assign popv   = src_drv_r ? drd : urd;
  assign pi     = popv[TW-1:0];
  assign look_a = (op_r == OP_SCHED || op_r == OP_BLOCK) ? ci : ti;
  assign tra    = cmd.pop_check ? pi : (cmd.lookup ? look_a : idle_r[TW-1:0]);
  assign create_ok = tid_ok &&
                     (dwe || uwe || (knd_r != KIND_USER && knd_r != KIND_DRIVER));

  assign sts.is_sched   = op_r == OP_SCHED && cpu_ok;
  assign sts.sched_done = cur == idle_r && dc_r == '0 && uc_r == '0 && cur_rdy;
  assign sts.q_empty    = dc_r == '0 && uc_r == '0;
  assign sts.pop_found  = pres(popv, valid_r);

  assign res_thread = res_thread_r;
  assign res_status = res_status_r;
  assign res_ns     = res_ns_r;
  assign res_sw     = res_sw_r;

  always_comb begin
    dwe = 1'b0;
    uwe = 1'b0;
    pdata = '0;
    if (cmd.exec && cpu_ok && op_r == OP_SCHED && !sts.sched_done && cur_rdy) begin
      pdata = cur;
      dwe = rk == KIND_DRIVER && !d_full;
      uwe = rk == KIND_USER && !u_full;
    end else if (cmd.exec && tid_ok && op_r == OP_WAKE && pres(tid_r, valid_r)
                 && rs == ST_WAIT) begin
      pdata = tid_r;
      dwe = rk == KIND_DRIVER && !d_full;
      uwe = rk != KIND_DRIVER && !u_full;
    end else if (cmd.exec && tid_ok && op_r == OP_CREATE) begin
      pdata = tid_r;
      dwe = knd_r == KIND_DRIVER && !d_full;
      uwe = knd_r == KIND_USER && !u_full;
    end
  end

  always_comb begin
    twe = 1'b0;
    twa = ti;
    twd = {rk, ST_READY};
    if (cmd.exec) begin
      case (op_r)
        OP_WAKE:   twe = dwe || uwe;
        OP_BLOCK: begin
          twa = ci;
          twd = {rk, ST_WAIT};
          twe = cpu_ok && pres(cur, valid_r);
        end
        OP_CREATE: begin
          twd = {knd_r, ST_NEW};
          twe = create_ok;
        end
        OP_REMOVE: begin
          twd = {rk, ST_DONE};
          twe = pres(tid_r, valid_r);
        end
        default:   twe = 1'b0;
      endcase
    end else if (cmd.finish) begin
      twa = ni;
      twe = pres(next_r, valid_r) && (rs == ST_NEW || rs == ST_WAIT);
    end
  end

  always_comb begin
    res_thread_nxt = res_thread_r;
    res_status_nxt = res_status_r;
    res_ns_nxt     = res_ns_r;
    res_sw_nxt     = res_sw_r;
    if (cmd.exec) begin
      res_ns_nxt     = 1'b0;
      res_sw_nxt     = 1'b0;
      res_status_nxt = RS_OK;
      res_thread_nxt = tid_r;
      unique case (op_r)
        OP_SCHED, OP_BLOCK: begin
          if (!cpu_ok) begin
            res_thread_nxt = '0;
            res_status_nxt = RS_NP;
          end else if (op_r == OP_BLOCK) begin
            res_thread_nxt = cur;
            if (!pres(cur, valid_r)) res_status_nxt = RS_NP;
          end else if (sts.sched_done) begin
            res_thread_nxt = cur;
          end else if (cur_rdy && ((rk == KIND_DRIVER && d_full) ||
                                   (rk == KIND_USER && u_full))) begin
            res_status_nxt = RS_FULL;
          end
        end
        OP_WAKE: begin
          if (!tid_ok || !pres(tid_r, valid_r)) res_status_nxt = RS_NP;
          else if (rs == ST_WAIT && !dwe && !uwe) res_status_nxt = RS_FULL;
        end
        OP_CREATE: begin
          if (!tid_ok) res_status_nxt = RS_NP;
          else if ((knd_r == KIND_DRIVER && d_full) || (knd_r == KIND_USER && u_full))
            res_status_nxt = RS_FULL;
        end
        OP_REMOVE: if (!pres(tid_r, valid_r)) res_status_nxt = RS_NP;
        default: res_status_nxt = RS_OK;
      endcase
    end else if (cmd.finish) begin
      res_thread_nxt = next_r;
      res_sw_nxt = 1'b1;
      res_ns_nxt = pres(next_r, valid_r) && (rs == ST_NEW || rs == ST_WAIT);
      if (!pres(next_r, valid_r) && res_status_r == RS_OK) res_status_nxt = RS_NP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r  <= '0;
      valid_r <= '0;
      dh_r <= '0; dt_r <= '0; dc_r <= '0;
      uh_r <= '0; ut_r <= '0; uc_r <= '0;
      for (int i = 0; i < NUM_CPUS; i++) run_r[i] <= '0;
    end else begin
      if (cfg_we) idle_r <= cfg_wdata;
      if (dwe) begin
        dt_r <= (32'(dt_r) == QUEUE_DEPTH - 1) ? '0 : dt_r + 1'b1;
        dc_r <= dc_r + 1'b1;
      end
      if (uwe) begin
        ut_r <= (32'(ut_r) == QUEUE_DEPTH - 1) ? '0 : ut_r + 1'b1;
        uc_r <= uc_r + 1'b1;
      end
      if (cmd.exec) begin
        if (op_r == OP_CREATE && create_ok) valid_r[ti] <= 1'b1;
        if (op_r == OP_REMOVE && pres(tid_r, valid_r)) valid_r[ti] <= 1'b0;
      end
      if (cmd.pop_issue && !sts.q_empty) begin
        if (dc_r != '0) begin
          dh_r <= (32'(dh_r) == QUEUE_DEPTH - 1) ? '0 : dh_r + 1'b1;
          dc_r <= dc_r - 1'b1;
        end else begin
          uh_r <= (32'(uh_r) == QUEUE_DEPTH - 1) ? '0 : uh_r + 1'b1;
          uc_r <= uc_r - 1'b1;
        end
      end
      if (cmd.finish) run_r[cpu_r[CW-1:0]] <= next_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_opcode; cpu_r <= in_cpu_id; tid_r <= in_thread_id; knd_r <= in_thread_kind;
    end
    if (cmd.pop_issue) begin
      src_drv_r <= dc_r != '0;
      next_r    <= idle_r;
    end
    if (cmd.pop_check) next_r <= popv;
    res_thread_r <= res_thread_nxt;
    res_status_r <= res_status_nxt;
    res_ns_r     <= res_ns_nxt;
    res_sw_r     <= res_sw_nxt;
  end
endmodule
`default_nettype wire

// ===== design/two_level_thread_scheduler.sv =====
// Two-level thread scheduler.
// in:  valid/ready item with opcode, cpu_id, thread_id, thread_kind.
// out: valid/ready item with result_thread, status, needs_start, switched.
// cfg: cfg_we/cfg_wdata writes the idle thread number; write only when idle.
// One item in flight. Every item starts with a thread table lookup state
// and an execute state. Wake, block, create, remove, unknown codes, schedules
// with an out-of-range CPU and the idle-keeps-running case then raise out valid.
// Other schedules pop FIFO entries, alternating a pop state and a check state
// through the registered FIFO RAM read, then pass a finish state before out
// valid; the idle thread is taken when every popped entry is skipped.
// The next item can be accepted in the cycle after the result is taken.
// A stalled receiver holds the result and the input stays not ready.
// Reset (synchronous, rst_n low) empties both FIFOs, clears the thread valid
// bits and running threads and sets the idle thread to 0; no clearing pass,
// kind and status entries are only read for valid threads.
`default_nettype none
module two_level_thread_scheduler #(
  parameter int QUEUE_DEPTH = 64
) (
  input wire logic       clk,
  input wire logic       rst_n,
  tlts_in_if.sink        in_ch,
  tlts_out_if.source     out_ch,
  input wire logic       cfg_we,
  input wire logic [5:0] cfg_wdata
);
  import tlts_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic in_fire, out_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cmd.out_valid;

  tlts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .in_ready(in_ch.ready));

  tlts_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_fire(in_fire),
    .in_opcode(in_ch.opcode), .in_cpu_id(in_ch.cpu_id), .in_thread_id(in_ch.thread_id),
    .in_thread_kind(in_ch.thread_kind), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .res_thread(out_ch.result_thread), .res_status(out_ch.status),
    .res_ns(out_ch.needs_start), .res_sw(out_ch.switched));
endmodule
`default_nettype wire

// ===== design/tlts_checker.sv =====
`default_nettype none
`include "two_level_thread_scheduler_defines.svh"
module tlts_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic       needs_start,
  input wire logic       switched
);
  `TLTS_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `TLTS_ASSERT_NXT(a_acc_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `TLTS_ASSERT_IMP(a_ns_sw, clk, rst_n, out_valid && needs_start, switched)
  `TLTS_ASSERT_IMP(a_stat, clk, rst_n, out_valid, status != 2'd3)
  `TLTS_ASSERT_NXT(a_done, clk, rst_n, out_valid && out_ready, !out_valid)
endmodule

bind two_level_thread_scheduler tlts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
  .needs_start(out_ch.needs_start), .switched(out_ch.switched));
`default_nettype wire
